// ----- hdl/uamq_pkg.sv -----
package uamq_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int DIST_W   = 31;
  localparam int ENTRY_W  = ID_W + DIST_W;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_EXTRACT  = 2'd1;
  localparam logic [1:0] OP_DECREASE = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Control from the sequencer to the shared compare unit.
  typedef struct packed {
    logic              start;
    logic              mode_dec;
    logic              use_key;
    logic              hit_valid;
    logic [ADDR_W-1:0] hit_pos;
  } scan_ctrl_t;

  // Result of the compare unit back to the sequencer.
  typedef struct packed {
    logic              found;
    logic              lt;
    logic [ADDR_W-1:0] best_pos;
    logic [ID_W-1:0]   best_id;
  } scan_stat_t;

endpackage

// ----- hdl/uamq_store.sv -----
module uamq_store
  import uamq_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  // Each word holds the id in the upper bits and the distance below it.
  logic [ENTRY_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/uamq_scan.sv -----
module uamq_scan
  import uamq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  scan_ctrl_t        ctrl,
  input  logic [ID_W-1:0]   hit_id,
  input  logic [DIST_W-1:0] hit_dist,
  input  logic [ID_W-1:0]   key_id,
  input  logic [DIST_W-1:0] key_dist,
  output scan_stat_t        stat
);

  logic              found;
  logic [DIST_W-1:0] best_d;
  logic [ADDR_W-1:0] best_pos;
  logic [ID_W-1:0]   best_id;
  logic [DIST_W-1:0] lhs;
  logic              lt;
  logic              take;

  // The single magnitude comparator serves both the minimum search and the
  // final check of a decrease against the matched entry.
  assign lhs = ctrl.use_key ? key_dist : hit_dist;
  assign lt  = lhs < best_d;

  always_comb begin
    if (ctrl.mode_dec) begin
      take = !found && (hit_id == key_id);
    end else begin
      take = !found || lt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.start) begin
      found <= 1'b0;
    end else if (ctrl.hit_valid && take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctrl.start && ctrl.hit_valid && take) begin
      best_d   <= hit_dist;
      best_pos <= ctrl.hit_pos;
      best_id  <= hit_id;
    end
  end

  assign stat.found    = found;
  assign stat.lt       = lt;
  assign stat.best_pos = best_pos;
  assign stat.best_id  = best_id;

endmodule

// ----- hdl/unsorted_array_min_queue_core.sv -----
// Unsorted-array min-priority queue of (node_id, distance) entries held in
// one single-port-write, registered-read memory of CAPACITY words. Each
// accepted transaction gives exactly one result transaction. Insert and
// clear go straight to the done state; the result is loaded into the
// output register at the same edge at which the input becomes ready again.
// Extract-min and decrease-distance walk the stored entries one per cycle
// through a single shared comparator, and extract then reads the last entry
// and moves it into the hole left by the minimum.
// The block takes one transaction at a time: in_ready is high only while the
// sequencer is idle, and the result sits in an output register until
// out_ready takes it. Ties on extract go to the lowest position, and a
// decrease changes only the first entry that carries the id, and only when
// the new distance is smaller.
module unsorted_array_min_queue_core
  import uamq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [ID_W-1:0]    node_id,
  input  logic [DIST_W-1:0]  distance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    out_id,
  output logic [1:0]         status,
  output logic               queue_empty,
  output logic [COUNT_W-1:0] entry_count
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] idx_next;
  logic               rd_valid;
  logic               rd_valid_next;
  logic [ADDR_W-1:0]  rd_pos;
  logic               is_dec;
  logic [ID_W-1:0]    key_id;
  logic [DIST_W-1:0]  key_dist;
  logic [ID_W-1:0]    res_id;
  logic [ID_W-1:0]    res_id_next;
  logic [1:0]         res_status;
  logic [1:0]         res_status_next;

  logic               accept;
  logic               full;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  scan_ctrl_t         sctrl;
  scan_stat_t         sstat;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (count == COUNT_W'(CAPACITY));

  uamq_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  uamq_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (sctrl),
    .hit_id   (rd_data[ENTRY_W-1:DIST_W]),
    .hit_dist (rd_data[DIST_W-1:0]),
    .key_id   (key_id),
    .key_dist (key_dist),
    .stat     (sstat)
  );

  // The sequencer. A scan issues one read per cycle; the data comes back in the
  // next cycle and is handed to the compare unit with the position it came
  // from. The scan ends once every position below count has been issued and
  // the last read has drained.
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    rd_valid_next   = 1'b0;
    res_id_next     = res_id;
    res_status_next = res_status;

    wr_en   = 1'b0;
    wr_addr = count[ADDR_W-1:0];
    wr_data = {node_id, distance};
    rd_en   = 1'b0;
    rd_addr = idx[ADDR_W-1:0];

    sctrl.start     = 1'b0;
    sctrl.mode_dec  = is_dec;
    sctrl.use_key   = 1'b0;
    sctrl.hit_valid = rd_valid;
    sctrl.hit_pos   = rd_pos;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_id_next     = '0;
          res_status_next = ST_OK;
          idx_next        = '0;
          sctrl.start     = 1'b1;
          case (op)
            OP_INSERT: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + COUNT_W'(1);
              end
              state_next = S_DONE;
            end
            OP_EXTRACT: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_DECREASE: begin
              state_next = S_SCAN;
            end
            default: begin
              count_next = '0;
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (idx < count) begin
          rd_en         = 1'b1;
          rd_valid_next = 1'b1;
          idx_next      = idx + COUNT_W'(1);
        end else if (!rd_valid) begin
          if (is_dec) begin
            // Compare the candidate against the matched entry's distance.
            sctrl.use_key = 1'b1;
            if (!sstat.found) begin
              res_status_next = ST_NOT_FOUND;
            end else if (sstat.lt) begin
              wr_en   = 1'b1;
              wr_addr = sstat.best_pos;
              wr_data = {key_id, key_dist};
            end
            state_next = S_DONE;
          end else begin
            // Fetch the last entry so it can fill the hole.
            rd_en      = 1'b1;
            rd_addr    = ADDR_W'(count - COUNT_W'(1));
            state_next = S_LAST;
          end
        end
      end

      S_LAST: begin
        wr_en       = 1'b1;
        wr_addr     = sstat.best_pos;
        wr_data     = rd_data;
        res_id_next = sstat.best_id;
        count_next  = count - COUNT_W'(1);
        state_next  = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rd_valid <= rd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    rd_pos     <= idx[ADDR_W-1:0];
    res_id     <= res_id_next;
    res_status <= res_status_next;
    if (accept) begin
      is_dec   <= (op == OP_DECREASE);
      key_id   <= node_id;
      key_dist <= distance;
    end
  end

  // Output register: loaded when the sequencer finishes and the previous
  // result has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_id      <= res_id;
      status      <= res_status;
      queue_empty <= (count == '0);
      entry_count <= count;
    end
  end

endmodule
